/* src/swft_pkg.sv */
// shared types and constants for the stop-and-wait frame transmitter
package swft_pkg;

  localparam int unsigned BurstLen = 8;
  localparam int unsigned CntW     = $clog2(BurstLen + 1);

  localparam logic [1:0] REQ_PAYLOAD = 2'd0;
  localparam logic [1:0] REQ_RESP    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_BAD_CHECK = 3'd1;
  localparam logic [2:0] ST_ADVANCED  = 3'd2;
  localparam logic [2:0] ST_RETX      = 3'd3;
  localparam logic [2:0] ST_TO_RETRY  = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] CTRL_REJ0 = 8'h54;
  localparam logic [7:0] CTRL_RR0  = 8'hAA;
  localparam logic [7:0] CTRL_REJ1 = 8'h55;
  localparam logic [7:0] CTRL_RR1  = 8'hAB;
  localparam logic [7:0] ADDR_RST  = 8'h03;
  localparam logic [3:0] MAX_RST   = 4'd3;
  localparam logic [3:0] CNT_MAX   = 4'd15;

  localparam logic CFG_ADDRESS = 1'b0;
  localparam logic CFG_MAX_ATT = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [7:0] resp_addr;
    logic [7:0] resp_ctrl;
    logic [7:0] resp_check;
  } swft_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic [2:0] status;
    logic       seq_bit;
    logic       last_result;
  } swft_out_t;

  typedef struct packed {
    logic       sequence_bit;
    logic       acked_bit;
    logic [7:0] payload_check;
    logic [3:0] attempt_count;
  } swft_state_t;

  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic                     kind;
    logic [2:0]               status;
    logic                     seq;
    logic [CntW-1:0]          count;
  } swft_burst_t;

endpackage

/* src/stop_wait_frame_transmitter.sv */
// top level: link state, configuration registers and result burst register
// the first result is presented from the burst register in the cycle after the request transfer
// one result per cycle while out_ready_i is high; a request with n results (1 to 8) holds
//   the burst register until its last result, and the next request transfers with that result
// reset: sequence, acked bit, check and attempt count clear; address 0x03, limit 3
// a request of the unused type is taken and yields nothing
module stop_wait_frame_transmitter import swft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  swft_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output swft_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  swft_state_t state_q, state_d;
  swft_burst_t burst_q, burst_d;
  logic [7:0]  addr_q;
  logic [3:0]  max_att_q;
  logic        in_xfer;
  logic        out_xfer;

  swft_encode u_encode (
    .req_i     (in_data_i),
    .state_i   (state_q),
    .address_i (addr_q),
    .max_att_i (max_att_q),
    .burst_o   (burst_d),
    .state_o   (state_d)
  );

  assign out_valid_o = (burst_q.count != '0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && (burst_q.count == CntW'(1)));
  assign in_xfer     = in_valid_i && in_ready_o;

  assign out_data_o.result_kind = burst_q.kind;
  assign out_data_o.tx_byte     = burst_q.bytes[0];
  assign out_data_o.status      = burst_q.status;
  assign out_data_o.seq_bit     = burst_q.seq;
  assign out_data_o.last_result = (burst_q.count == CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      burst_q   <= '0;
      addr_q    <= ADDR_RST;
      max_att_q <= MAX_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ADDRESS: addr_q    <= cfg_data_i;
          CFG_MAX_ATT: max_att_q <= cfg_data_i[3:0];
          default:     addr_q    <= addr_q;
        endcase
      end
      if (in_xfer) begin
        state_q <= state_d;
        burst_q <= burst_d;
      end else if (out_xfer) begin
        burst_q.bytes <= burst_q.bytes >> 8;
        burst_q.count <= burst_q.count - CntW'(1);
      end
    end
  end

  // sequence bit moves only on an accepted response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && in_data_i.req_type == REQ_RESP) |=> $stable(state_q.sequence_bit))
    else $error("sequence bit changed without a response transfer");

  // attempt count moves only on a response or a timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && (in_data_i.req_type == REQ_RESP || in_data_i.req_type == REQ_TIMEOUT))
    |=> $stable(state_q.attempt_count))
    else $error("attempt count changed without a response or timeout");

  // a status report is always the only result of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind |-> out_data_o.last_result)
    else $error("status report not marked as final result");

endmodule

/* src/swft_encode.sv */
// builds the result burst and next link state for one request
module swft_encode import swft_pkg::*; (
  input  swft_in_t    req_i,
  input  swft_state_t state_i,
  input  logic [7:0]  address_i,
  input  logic [3:0]  max_att_i,
  output swft_burst_t burst_o,
  output swft_state_t state_o
);

  logic [CntW-1:0] n;
  logic [7:0]      ctrl;
  logic [7:0]      pc;
  logic [3:0]      att;
  logic            acked;

  always_comb begin
    burst_o = '0;
    state_o = state_i;
    n       = '0;
    ctrl    = {7'd0, state_i.sequence_bit};
    pc      = '0;
    att     = state_i.attempt_count;
    acked   = state_i.acked_bit;
    burst_o.seq = state_i.sequence_bit;
    unique case (req_i.req_type)
      REQ_PAYLOAD: begin
        if (req_i.first_of_frame) begin
          burst_o.bytes[0] = FLAG_BYTE;
          burst_o.bytes[1] = address_i;
          burst_o.bytes[2] = ctrl;
          burst_o.bytes[3] = address_i ^ ctrl;
          n = CntW'(4);
        end else begin
          pc = state_i.payload_check;
        end
        pc = pc ^ req_i.data_byte;
        if (req_i.data_byte == FLAG_BYTE) begin
          burst_o.bytes[n[2:0]]        = ESC_BYTE;
          burst_o.bytes[n[2:0] + 3'd1] = ESC_FLAG;
          n = n + CntW'(2);
        end else if (req_i.data_byte == ESC_BYTE) begin
          burst_o.bytes[n[2:0]]        = ESC_BYTE;
          burst_o.bytes[n[2:0] + 3'd1] = ESC_ESC;
          n = n + CntW'(2);
        end else begin
          burst_o.bytes[n[2:0]] = req_i.data_byte;
          n = n + CntW'(1);
        end
        if (req_i.last_of_frame) begin
          burst_o.bytes[n[2:0]]        = pc;
          burst_o.bytes[n[2:0] + 3'd1] = FLAG_BYTE;
          n = n + CntW'(2);
        end
        state_o.payload_check = pc;
        burst_o.count = n;
      end
      REQ_RESP: begin
        burst_o.kind  = 1'b1;
        burst_o.count = CntW'(1);
        if (req_i.resp_check != (req_i.resp_addr ^ req_i.resp_ctrl)) begin
          burst_o.status = ST_BAD_CHECK;
        end else begin
          priority if (req_i.resp_ctrl == CTRL_REJ0) begin
            acked = 1'b0;
          end else if (req_i.resp_ctrl == CTRL_RR0) begin
            acked = 1'b0;
            att   = '0;
          end else if (req_i.resp_ctrl == CTRL_REJ1) begin
            acked = 1'b1;
          end else if (req_i.resp_ctrl == CTRL_RR1) begin
            acked = 1'b1;
            att   = '0;
          end else begin
            acked = state_i.acked_bit;
          end
          state_o.acked_bit     = acked;
          state_o.attempt_count = att;
          if (acked == state_i.sequence_bit) begin
            burst_o.status = ST_RETX;
          end else begin
            state_o.sequence_bit = ~state_i.sequence_bit;
            burst_o.seq          = ~state_i.sequence_bit;
            burst_o.status       = ST_ADVANCED;
          end
        end
      end
      REQ_TIMEOUT: begin
        burst_o.kind  = 1'b1;
        burst_o.count = CntW'(1);
        if (att != CNT_MAX) begin
          att = att + 4'd1;
        end
        state_o.attempt_count = att;
        burst_o.status = (att >= max_att_i) ? ST_EXHAUSTED : ST_TO_RETRY;
      end
      default: begin
        burst_o.count = '0;
      end
    endcase
  end

endmodule

/* bench/tb.sv */
// testbench for the stop-and-wait frame transmitter: framing, escaping, ack decode and timeouts
`timescale 1ns / 1ps

module tb import swft_pkg::*; ();

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;
  localparam int unsigned MaxShown   = 40;

  class arq_tracker;
    logic [7:0] address_reg;
    logic [3:0] attempt_limit;
    logic       seq_now;
    logic       acked_now;
    logic [7:0] frame_check;
    logic [3:0] attempts;
    swft_out_t  due_results[$];
    int unsigned errors;

    function new();
      address_reg   = ADDR_RST;
      attempt_limit = MAX_RST;
      seq_now       = 1'b0;
      acked_now     = 1'b0;
      frame_check   = '0;
      attempts      = '0;
      errors        = 0;
    endfunction

    function void set_reg(logic index, logic [7:0] value);
      if (index == CFG_ADDRESS) begin
        address_reg = value;
      end else begin
        attempt_limit = value[3:0];
      end
    endfunction

    function swft_out_t byte_entry(logic [7:0] b);
      swft_out_t e;
      e.result_kind = KIND_BYTE;
      e.tx_byte     = b;
      e.status      = ST_NONE;
      e.seq_bit     = seq_now;
      e.last_result = 1'b0;
      return e;
    endfunction

    function swft_out_t status_entry(logic [2:0] st);
      swft_out_t e;
      e.result_kind = KIND_REPORT;
      e.tx_byte     = 8'h00;
      e.status      = st;
      e.seq_bit     = seq_now;
      e.last_result = 1'b0;
      return e;
    endfunction

    function void accept_request(swft_in_t req);
      swft_out_t burst[$];
      swft_out_t tail;
      case (req.req_type)
        REQ_PAYLOAD: begin
          if (req.first_of_frame) begin
            frame_check = '0;
            burst.push_back(byte_entry(FLAG_BYTE));
            burst.push_back(byte_entry(address_reg));
            burst.push_back(byte_entry({7'd0, seq_now}));
            burst.push_back(byte_entry(address_reg ^ {7'd0, seq_now}));
          end
          if (req.data_byte == FLAG_BYTE || req.data_byte == ESC_BYTE) begin
            burst.push_back(byte_entry(ESC_BYTE));
            burst.push_back(byte_entry(req.data_byte == FLAG_BYTE ? ESC_FLAG : ESC_ESC));
          end else begin
            burst.push_back(byte_entry(req.data_byte));
          end
          frame_check = frame_check ^ req.data_byte;
          if (req.last_of_frame) begin
            burst.push_back(byte_entry(frame_check));
            burst.push_back(byte_entry(FLAG_BYTE));
          end
        end
        REQ_RESP: begin
          if (req.resp_check != (req.resp_addr ^ req.resp_ctrl)) begin
            burst.push_back(status_entry(ST_BAD_CHECK));
          end else begin
            case (req.resp_ctrl)
              CTRL_REJ0: acked_now = 1'b0;
              CTRL_RR0: begin
                acked_now = 1'b0;
                attempts  = '0;
              end
              CTRL_REJ1: acked_now = 1'b1;
              CTRL_RR1: begin
                acked_now = 1'b1;
                attempts  = '0;
              end
              default: ;
            endcase
            if (acked_now == seq_now) begin
              burst.push_back(status_entry(ST_RETX));
            end else begin
              seq_now = ~seq_now;
              burst.push_back(status_entry(ST_ADVANCED));
            end
          end
        end
        REQ_TIMEOUT: begin
          if (attempts != CNT_MAX) attempts = attempts + 4'd1;
          burst.push_back(status_entry(attempts >= attempt_limit ? ST_EXHAUSTED : ST_TO_RETRY));
        end
        default: ;
      endcase
      if (burst.size() != 0) begin
        tail = burst.pop_back();
        tail.last_result = 1'b1;
        burst.push_back(tail);
      end
      foreach (burst[k]) due_results.push_back(burst[k]);
    endfunction

    function void compare_result(swft_out_t got);
      swft_out_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("%0t: unexpected result kind %0d byte %02h status %0d seq %0d last %0d",
                   $time, got.result_kind, got.tx_byte, got.status, got.seq_bit,
                   got.last_result);
        return;
      end
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind || got.tx_byte !== want.tx_byte ||
          got.status !== want.status || got.seq_bit !== want.seq_bit ||
          got.last_result !== want.last_result) begin
        errors++;
        if (errors <= MaxShown)
          $display({"%0t: mismatch expected kind %0d byte %02h status %0d seq %0d last %0d,",
                    " actual kind %0d byte %02h status %0d seq %0d last %0d"},
                   $time, want.result_kind, want.tx_byte, want.status, want.seq_bit,
                   want.last_result, got.result_kind, got.tx_byte, got.status,
                   got.seq_bit, got.last_result);
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  swft_in_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  swft_out_t  out_data_o;
  logic       cfg_we_i;
  logic       cfg_index_i;
  logic [7:0] cfg_data_i;

  arq_tracker  tracker;
  bit          hold_off_req = 1'b0;
  int unsigned issued = 0;
  int unsigned burst_left = 0;

  stop_wait_frame_transmitter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic swft_in_t random_req();
    swft_in_t r;
    r.req_type       = REQ_UNUSED;
    r.data_byte      = 8'($urandom_range(0, 255));
    r.first_of_frame = 1'($urandom_range(0, 1));
    r.last_of_frame  = 1'($urandom_range(0, 1));
    r.resp_addr      = 8'($urandom_range(0, 255));
    r.resp_ctrl      = 8'($urandom_range(0, 255));
    r.resp_check     = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic swft_in_t payload_req(logic [7:0] d, logic first, logic last);
    swft_in_t r;
    r = random_req();
    r.req_type       = REQ_PAYLOAD;
    r.data_byte      = d;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    return r;
  endfunction

  function automatic swft_in_t response_req(logic [7:0] addr, logic [7:0] ctrl,
                                            logic [7:0] check);
    swft_in_t r;
    r = random_req();
    r.req_type   = REQ_RESP;
    r.resp_addr  = addr;
    r.resp_ctrl  = ctrl;
    r.resp_check = check;
    return r;
  endfunction

  function automatic swft_in_t tick_req();
    swft_in_t r;
    r = random_req();
    r.req_type = REQ_TIMEOUT;
    return r;
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_ctrl();
    case ($urandom_range(0, 3))
      0: return CTRL_RR0;
      1: return CTRL_RR1;
      2: return CTRL_REJ0;
      default: return CTRL_REJ1;
    endcase
  endfunction

  task automatic issue(swft_in_t req);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.accept_request(req);
    if (req.req_type != REQ_UNUSED) issued++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic index, logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    tracker.set_reg(index, value);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_traffic(int unsigned quota);
    int unsigned start;
    int unsigned len;
    int unsigned choice;
    logic [7:0]  addr;
    logic [7:0]  ctrl;
    start = issued;
    while (issued - start < quota) begin
      choice = $urandom_range(0, 19);
      if (choice < 13) begin
        // well-formed frame, optional timeouts, then a valid ack or reject
        len = (choice == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
        for (int unsigned k = 0; k < len; k++)
          issue(payload_req(pick_data(), k == 0, k == len - 1));
        if (choice[0]) repeat ($urandom_range(1, 3)) issue(tick_req());
        addr = $urandom_range(0, 1) ? tracker.address_reg : 8'($urandom_range(0, 255));
        ctrl = pick_ctrl();
        issue(response_req(addr, ctrl, addr ^ ctrl));
      end else if (choice < 15) begin
        repeat ($urandom_range(12, 18)) issue(tick_req());
      end else if (choice < 17) begin
        addr = 8'($urandom_range(0, 255));
        ctrl = 8'($urandom_range(0, 255));
        issue(response_req(addr, ctrl,
                           $urandom_range(0, 1) ? addr ^ ctrl : 8'($urandom_range(0, 255))));
      end else if (choice == 17) begin
        issue(random_req());
      end else begin
        issue(payload_req(pick_data(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin : receiver
    int unsigned hold_left;
    int unsigned cyc;
    out_ready_i = 1'b0;
    hold_left   = 0;
    cyc         = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) tracker.compare_result(out_data_o);
      cyc++;
      if (hold_off_req && hold_left == 0) begin
        hold_left    = 80;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((cyc / 90) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 1);
          2: out_ready_i <= (cyc % 5 == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #2_400_000;
    $display("stop_wait_frame_transmitter verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_ADDRESS;
    cfg_data_i  = '0;
    tracker     = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // escapes, extremes and continuation
    issue(payload_req(8'h00, 1'b1, 1'b0));
    issue(payload_req(FLAG_BYTE, 1'b0, 1'b0));
    issue(payload_req(ESC_BYTE, 1'b0, 1'b0));
    issue(payload_req(8'hFF, 1'b0, 1'b1));
    issue(response_req(8'h03, CTRL_RR1, 8'h03 ^ CTRL_RR1));
    issue(response_req(8'hFF, CTRL_RR0, 8'h00));
    issue(payload_req(FLAG_BYTE, 1'b1, 1'b1));
    issue(response_req(8'h00, CTRL_REJ1, CTRL_REJ1));
    issue(response_req(8'hFF, CTRL_RR0, 8'hFF ^ CTRL_RR0));
    issue(response_req(8'h5A, CTRL_REJ0, 8'h5A ^ CTRL_REJ0));
    issue(payload_req(8'h5A, 1'b0, 1'b0));
    issue(payload_req(ESC_BYTE, 1'b0, 1'b1));
    // unknown control with a good check
    issue(response_req(8'hFF, 8'h00, 8'hFF));
    repeat (4) issue(tick_req());
    // traffic after exhaustion
    issue(payload_req(8'h81, 1'b1, 1'b1));
    issue(response_req(8'h03, CTRL_REJ1, 8'h03 ^ CTRL_REJ1));
    issue(tick_req());
    issue(response_req(8'h03, CTRL_RR0, 8'h03 ^ CTRL_RR0));
    issue(tick_req());
    issue(random_req());
    wait_idle();

    write_reg(CFG_ADDRESS, 8'h00);
    write_reg(CFG_MAX_ATT, 8'd0);
    run_traffic(48);
    wait_idle();

    write_reg(CFG_ADDRESS, 8'hFF);
    write_reg(CFG_MAX_ATT, 8'd15);
    hold_off_req = 1'b1;
    run_traffic(48);
    wait_idle();

    write_reg(CFG_ADDRESS, FLAG_BYTE);
    write_reg(CFG_MAX_ATT, 8'd1);
    run_traffic(48);
    wait_idle();

    write_reg(CFG_ADDRESS, 8'($urandom_range(0, 255)));
    write_reg(CFG_MAX_ATT, 8'($urandom_range(0, 15)));
    hold_off_req = 1'b1;
    run_traffic(48);
    wait_idle();

    if (tracker.errors == 0) begin
      $display("stop_wait_frame_transmitter verification clean");
    end else begin
      $display("stop_wait_frame_transmitter verification failed");
    end
    $finish;
  end

endmodule
